// File: sv/ordered_list_insert_macros.svh
// Assertion macros for the ordered list insert block.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef ORDERED_LIST_INSERT_MACROS_SVH
`define ORDERED_LIST_INSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define OLI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ordered list insert check failed");
// Next-cycle implication, disabled while reset is asserted.
`define OLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ordered list insert check failed");
`else
`define OLI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OLI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/oli_pkg.sv
// Shared types and codes for the ordered list insert block.
// Used by oli_cell and ordered_list_insert; depends on nothing.
package oli_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int CMP_W   = POS_W + 1;
    localparam int ST_W    = 2;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST_FWD  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST_BWD  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          position;
    } t_in_word;

    typedef struct packed {
        logic [ST_W-1:0]           status;
        logic signed [VALUE_W-1:0] out_value;
        logic                      last_of_run;
    } t_out_word;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_ROT_L,
        CM_ROT_R
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode       mode;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

// File: sv/oli_cell.sv
// One storage cell of the ordered list chain.
// Depends on oli_pkg for the cell control struct.
module oli_cell import oli_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_load_val,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_val
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.mode)
            CM_INSERT: begin
                // load at the target slot, shift back everything behind it
                if (MY_IDX == i_ctl.pos) begin
                    n_val = i_load_val;
                end else if (MY_IDX > i_ctl.pos) begin
                    n_val = i_left;
                end
            end
            CM_ROT_L: n_val = i_right;
            CM_ROT_R: n_val = i_left;
            default:  n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// File: sv/ordered_list_insert.sv
// Ordered list insert: top level with command control and a chain of cells.
// Depends on oli_pkg, oli_cell and ordered_list_insert_macros.svh.
// Insert: status word on the strobe the next cycle; a new
//   command may start every cycle while inserts follow each other.
// Listing: busy while the chain turns once; the next command is taken after the
//   turn ends. Forward words leave one a cycle from the start of the turn; backward
//   words leave one a cycle at the end of the turn, once the tail reaches the last cell.
// Reset (synchronous, active low) empties the list; cell contents stay as is.
`include "ordered_list_insert_macros.svh"
module ordered_list_insert import oli_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_in,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_out
);

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = $clog2(CAPACITY);
    localparam logic [LEN_W-1:0]  LEN_FULL  = LEN_W'(CAPACITY);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CAPACITY - 1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    t_state              r_state;
    logic [LEN_W-1:0]    r_len;
    logic [STEP_W-1:0]   r_step;
    logic                r_dir;       // 1: back to front
    logic                r_strobe;
    t_out_word           r_out;

    logic                  w_accept;
    logic                  w_is_ins;
    logic                  w_is_list;
    logic                  w_full;
    logic                  w_bad;
    logic [POS_W-1:0]      w_ins_pos;
    logic [VALUE_W-1:0]    w_raw;
    logic [DATA_WIDTH-1:0] w_load_val;
    logic [ST_W-1:0]       w_ins_status;
    logic                  w_emit;
    logic                  w_last;
    logic [LEN_W-1:0]      w_step_ext;
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_cell_val [CAPACITY];

    assign busy     = (r_state == S_LIST);
    assign w_accept = start && !busy;

    assign w_is_ins  = (i_in.command == CMD_INS_FRONT) || (i_in.command == CMD_INS_BACK) ||
                       (i_in.command == CMD_INS_POS);
    assign w_is_list = (i_in.command == CMD_LIST_FWD) || (i_in.command == CMD_LIST_BWD);

    // Full takes priority over the index check.
    assign w_full = (r_len == LEN_FULL);
    assign w_bad  = (i_in.command == CMD_INS_POS) && (r_len != '0) &&
                    (i_in.position != '0) &&
                    ({1'b0, i_in.position} > CMP_W'(r_len));

    always_comb begin
        case (i_in.command)
            CMD_INS_BACK: w_ins_pos = POS_W'(r_len);
            CMD_INS_POS:  w_ins_pos = (r_len == '0) ? '0 : i_in.position;
            default:      w_ins_pos = '0;
        endcase
    end

    assign w_ins_status = w_full ? ST_FULL : (w_bad ? ST_BAD_INDEX : ST_OK);

    // Store the item in DATA_WIDTH bits: zero-extend or drop upper bits.
    assign w_raw      = i_in.item_value;
    assign w_load_val = DATA_WIDTH'(w_raw);

    // Cell control: rotate during a listing, shift-insert on an accepted insert.
    always_comb begin
        w_ctl.mode = CM_HOLD;
        w_ctl.pos  = w_ins_pos;
        if (r_state == S_LIST) begin
            w_ctl.mode = r_dir ? CM_ROT_R : CM_ROT_L;
        end else if (w_accept && w_is_ins && !w_full && !w_bad) begin
            w_ctl.mode = CM_INSERT;
        end
    end

    // Forward: emit the head for the first r_len steps, rotating left.
    // Backward: rotate right silently until the tail reaches the last cell,
    // then emit the last cell for the remaining r_len steps.
    assign w_step_ext = LEN_W'(r_step);
    always_comb begin
        if (r_dir) begin
            w_emit = (w_step_ext >= (LEN_FULL - r_len));
            w_last = (r_step == STEP_LAST);
        end else begin
            w_emit = (w_step_ext < r_len);
            w_last = (w_step_ext == (r_len - 1'b1));
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        oli_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_load_val (w_load_val),
            .i_left     (w_cell_val[(g + CAPACITY - 1) % CAPACITY]),
            .i_right    (w_cell_val[(g + 1) % CAPACITY]),
            .o_val      (w_cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_step   <= '0;
            r_dir    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_is_ins) begin
                        // one status word per insert
                        r_strobe          <= 1'b1;
                        r_out.status      <= w_ins_status;
                        r_out.out_value   <= '0;
                        r_out.last_of_run <= 1'b1;
                        if (w_ins_status == ST_OK) begin
                            r_len <= r_len + 1'b1;
                        end
                    end else if (w_accept && w_is_list) begin
                        if (r_len == '0) begin
                            r_strobe          <= 1'b1;
                            r_out.status      <= ST_EMPTY;
                            r_out.out_value   <= '0;
                            r_out.last_of_run <= 1'b1;
                        end else begin
                            r_state <= S_LIST;
                            r_step  <= '0;
                            r_dir   <= (i_in.command == CMD_LIST_BWD);
                        end
                    end
                end
                S_LIST: begin
                    r_strobe          <= w_emit;
                    r_out.status      <= ST_OK;
                    r_out.out_value   <= VALUE_W'(r_dir ? w_cell_val[CAPACITY-1]
                                                        : w_cell_val[0]);
                    r_out.last_of_run <= w_last;
                    r_step            <= r_step + 1'b1;
                    // a full turn restores the original order
                    if (r_step == STEP_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // Length never passes the store size.
    `OLI_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LEN_FULL)
    // Every accepted insert answers with a final status word next cycle.
    `OLI_ASSERT_NEXT(a_ins_reply, i_clk, i_rst_n, w_accept && w_is_ins,
                     o_strobe && o_out.last_of_run && !busy)
    // A listing of a non-empty list holds the block busy.
    `OLI_ASSERT_NEXT(a_list_busy, i_clk, i_rst_n, w_accept && w_is_list && (r_len != '0),
                     busy && (r_step == '0))
    // The final step of a listing releases the block.
    `OLI_ASSERT_NEXT(a_list_done, i_clk, i_rst_n, busy && (r_step == STEP_LAST), !busy)

endmodule
